// ===== hw/rtl/pvdc_pkg.sv =====
// shared types, constants and codes for the pressure valve dead-zone controller
`timescale 1ns / 1ps

package pvdc_pkg;

  // stream packing
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INFLATE_SPAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFLATE_SPAN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MIN_POS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MAX_POS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MIN_NEG = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MAX_NEG = 3'd6;

  // pressure limits and band factors
  localparam logic signed [18:0] TARGET_LOW  = -19'sd100000;
  localparam logic signed [18:0] TARGET_HIGH = 19'sd180000;
  localparam int RISE_BAND_FACTOR = 10;
  localparam int HOLD_BAND_FACTOR = 100;
  localparam logic signed [17:0] OPEN_LIMIT = 18'sd32767;

  // serial multiply / divide
  localparam int MD_DIGITS = 16;
  localparam int MD_CNT_W  = 4;
  localparam logic [MD_CNT_W-1:0] MD_CNT_LAST = MD_CNT_W'(MD_DIGITS - 1);

  typedef struct packed {
    logic [15:0] dead_zone;
    logic [17:0] inflate_span;
    logic [17:0] deflate_span;
    logic [14:0] open_min_pos;
    logic [14:0] open_max_pos;
    logic [15:0] open_min_neg;
    logic [15:0] open_max_neg;
  } cfg_t;

  // one linear segment: clamp bounds, end values, hold request
  typedef struct packed {
    logic [19:0] lo;
    logic [19:0] hi;
    logic [15:0] a;
    logic [15:0] b;
    logic        hold;
  } seg_t;

  // operands for the serial unit: q = (x * y) / den
  typedef struct packed {
    logic [18:0] x;
    logic [15:0] y;
    logic [18:0] den;
  } md_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_BAND,
    ST_CALC,
    ST_DONE
  } top_state_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_DIV
  } seq_state_t;

endpackage

// ===== hw/rtl/pvdc_band.sv =====
// segment selection from the pressure error, mode and target rate
`timescale 1ns / 1ps

module pvdc_band
  import pvdc_pkg::*;
(
  input  logic [19:0] err,
  input  cfg_t        cfg,
  input  logic        rate_aware,
  input  logic        rising,
  output seg_t        seg
);

  logic signed [24:0] e25;
  logic signed [24:0] dz25;
  logic signed [24:0] dz10_25;
  logic signed [24:0] dz100_25;
  logic signed [19:0] dz20;
  logic signed [19:0] ip20;
  logic signed [19:0] dp20;
  logic [15:0]        min_pos16;
  logic [15:0]        max_pos16;

  always_comb begin
    e25       = {{5{err[19]}}, err};
    dz25      = {9'b0, cfg.dead_zone};
    dz10_25   = 25'(cfg.dead_zone) * 25'(RISE_BAND_FACTOR);
    dz100_25  = 25'(cfg.dead_zone) * 25'(HOLD_BAND_FACTOR);
    dz20      = {4'b0, cfg.dead_zone};
    ip20      = {2'b0, cfg.inflate_span};
    dp20      = {2'b0, cfg.deflate_span};
    min_pos16 = {1'b0, cfg.open_min_pos};
    max_pos16 = {1'b0, cfg.open_max_pos};

    // default: empty segment at zero, gives a closed valve
    seg.lo   = '0;
    seg.hi   = '0;
    seg.a    = '0;
    seg.b    = '0;
    seg.hold = 1'b0;

    priority if (!rate_aware) begin
      priority if (e25 > dz25) begin
        seg.lo = dz20;
        seg.hi = ip20;
        seg.a  = min_pos16;
        seg.b  = max_pos16;
      end else if (e25 < -dz25) begin
        seg.lo = -dp20;
        seg.hi = -dz20;
        seg.a  = cfg.open_min_neg;
        seg.b  = cfg.open_max_neg;
      end else begin
        // inside the dead zone: empty segment at zero
        seg.lo = '0;
        seg.hi = '0;
      end
    end else if (rising) begin
      priority if (e25 > dz25) begin
        seg.lo = dz20;
        seg.hi = ip20;
        seg.a  = min_pos16;
        seg.b  = max_pos16;
      end else if (e25 < -dz10_25) begin
        seg.lo = -dp20;
        seg.hi = -dz20;
        seg.a  = cfg.open_min_neg;
        seg.b  = cfg.open_max_neg;
      end else begin
        seg.lo = -dp20;
        seg.hi = dz20;
        seg.a  = '0;
        seg.b  = min_pos16;
      end
    end else begin
      priority if (e25 < -dz25) begin
        // falling target uses the inflate span on the exhaust side
        seg.lo = -ip20;
        seg.hi = -dz20;
        seg.a  = cfg.open_min_neg;
        seg.b  = cfg.open_max_neg;
      end else if (e25 > dz100_25) begin
        seg.hold = 1'b1;
      end else begin
        seg.lo = -dz20;
        seg.hi = '0;
        seg.a  = cfg.open_max_neg;
        seg.b  = '0;
      end
    end
  end

endmodule

// ===== hw/rtl/pvdc_muldiv.sv =====
// bit-serial shift-add multiply followed by restoring divide
`timescale 1ns / 1ps

module pvdc_muldiv
  import pvdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  md_req_t     req,
  output logic        done,
  output logic [15:0] quo
);

  seq_state_t          seq_r, seq_nxt;
  logic [MD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [18:0]         hi_r, hi_nxt;
  logic [15:0]         lo_r, lo_nxt;
  logic [18:0]         x_r, x_nxt;
  logic [18:0]         den_r, den_nxt;

  logic [19:0]         sum;
  logic [20:0]         trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= SEQ_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      seq_r  <= seq_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    x_r   <= x_nxt;
    den_r <= den_nxt;
  end

  always_comb begin
    seq_nxt  = seq_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    x_nxt    = x_r;
    den_nxt  = den_r;

    // multiply digit: add x when the low bit is set, shift right
    sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, x_r} : 20'd0);
    // divide digit: shift in the next numerator bit, try a subtract
    trial = {1'b0, hi_r, lo_r[15]} - {2'b0, den_r};

    unique case (seq_r)
      SEQ_IDLE: begin
        if (start) begin
          hi_nxt  = '0;
          lo_nxt  = req.y;
          x_nxt   = req.x;
          den_nxt = req.den;
          cnt_nxt = '0;
          seq_nxt = SEQ_MUL;
        end
      end
      SEQ_MUL: begin
        hi_nxt  = sum[19:1];
        lo_nxt  = {sum[0], lo_r[15:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MD_CNT_LAST) begin
          cnt_nxt = '0;
          seq_nxt = SEQ_DIV;
        end
      end
      SEQ_DIV: begin
        // high part is below den here, so the quotient fits the low part
        hi_nxt  = trial[20] ? {hi_r[17:0], lo_r[15]} : trial[18:0];
        lo_nxt  = {lo_r[14:0], !trial[20]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MD_CNT_LAST) begin
          cnt_nxt  = '0;
          done_nxt = 1'b1;
          seq_nxt  = SEQ_IDLE;
        end
      end
      default: seq_nxt = SEQ_IDLE;
    endcase
  end

  assign done = done_r;
  assign quo  = lo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> seq_r == SEQ_IDLE)
    else $error("serial unit started while busy");

  a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> seq_r == SEQ_MUL && cnt_r == '0)
    else $error("serial unit did not enter multiply");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r && seq_r == SEQ_IDLE)
    else $error("done not a single pulse");

endmodule

// ===== hw/rtl/pressure_valve_deadzone_controller.sv =====
// top level of the pressure valve dead-zone controller
// a sloped segment runs ST_IDLE, ST_ERR, ST_BAND, ST_CALC and ST_DONE; a held opening,
//   a closed valve or an empty segment skips ST_CALC
// one request at a time, taken in ST_IDLE only; ST_CALC waits on the 16-step
//   shift-add multiply and 16-step restoring divide in pvdc_muldiv
// reset (rst_n low, synchronous): control and configuration registers take their
//   defaults, last opening 0, inflating mode 1, both channels empty
`timescale 1ns / 1ps

module pressure_valve_deadzone_controller
  import pvdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // target_pressure[18:0], measured_pressure[37:19], zero pad [39:38]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command[0], target_rising[1]
  input  logic [IN_USER_W-1:0]  in_tuser,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // valve_opening[15:0], inflate_duty[30:16], exhaust_duty[45:31], zero pad [47:46]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // inflating[0]
  output logic [OUT_USER_W-1:0] out_tuser,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // control state
  top_state_t              state_r, state_nxt;
  cfg_t                    cfg_r, cfg_nxt;
  logic                    mode_r, mode_nxt;
  logic [15:0]             last_r, last_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // request and working payload
  logic                    cmd_r, cmd_nxt;
  logic                    rise_r, rise_nxt;
  logic [18:0]             tgt_r, tgt_nxt;
  logic [18:0]             meas_r, meas_nxt;
  logic [19:0]             err_r, err_nxt;
  logic [15:0]             a_r, a_nxt;
  logic                    neg_r, neg_nxt;
  logic [17:0]             res_r, res_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0]   out_user_r, out_user_nxt;

  // datapath helpers
  seg_t                    seg;
  md_req_t                 md_req;
  logic                    md_start;
  logic                    md_done;
  logic [15:0]             md_quo;

  logic signed [18:0]      tgt_s;
  logic signed [18:0]      tgt_c;
  logic signed [20:0]      lo21;
  logic signed [20:0]      hi21;
  logic signed [20:0]      span21;
  logic signed [19:0]      e_s;
  logic signed [19:0]      e_c;
  logic signed [20:0]      off21;
  logic signed [16:0]      dba17;
  logic [16:0]             mag17;
  logic signed [17:0]      res_s;
  logic signed [15:0]      op;
  logic signed [15:0]      op_neg;
  logic                    in_acc;
  logic                    out_free;

  pvdc_band u_band (
    .err        (err_r),
    .cfg        (cfg_r),
    .rate_aware (cmd_r),
    .rising     (rise_r),
    .seg        (seg)
  );

  pvdc_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .req   (md_req),
    .done  (md_done),
    .quo   (md_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      cfg_r.dead_zone    <= 16'd2000;
      cfg_r.inflate_span <= 18'd20000;
      cfg_r.deflate_span <= 18'd20000;
      cfg_r.open_min_pos <= 15'd5898;
      cfg_r.open_max_pos <= 15'd7537;
      cfg_r.open_min_neg <= 16'hdccd;   // -9011
      cfg_r.open_max_neg <= 16'hdeb8;   // -8520
      mode_r             <= 1'b1;
      last_r             <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      mode_r      <= mode_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rise_r     <= rise_nxt;
    tgt_r      <= tgt_nxt;
    meas_r     <= meas_nxt;
    err_r      <= err_nxt;
    a_r        <= a_nxt;
    neg_r      <= neg_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // configuration writes, always ready
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEAD_ZONE:    cfg_nxt.dead_zone    = cfg_data[15:0];
        CFG_INFLATE_SPAN: cfg_nxt.inflate_span = cfg_data[17:0];
        CFG_DEFLATE_SPAN: cfg_nxt.deflate_span = cfg_data[17:0];
        CFG_OPEN_MIN_POS: cfg_nxt.open_min_pos = cfg_data[14:0];
        CFG_OPEN_MAX_POS: cfg_nxt.open_max_pos = cfg_data[14:0];
        CFG_OPEN_MIN_NEG: cfg_nxt.open_min_neg = cfg_data[15:0];
        CFG_OPEN_MAX_NEG: cfg_nxt.open_max_neg = cfg_data[15:0];
        default:          cfg_nxt = cfg_r;   // unmapped index, dropped
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    last_nxt      = last_r;
    cmd_nxt       = cmd_r;
    rise_nxt      = rise_r;
    tgt_nxt       = tgt_r;
    meas_nxt      = meas_r;
    err_nxt       = err_r;
    a_nxt         = a_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    md_start      = 1'b0;

    in_acc   = in_tvalid && (state_r == ST_IDLE);
    out_free = !out_valid_r || out_tready;
    out_valid_nxt = out_valid_r && !out_tready;

    // clamp the target, then error = target - measured
    tgt_s = tgt_r;
    if (tgt_s < TARGET_LOW) begin
      tgt_c = TARGET_LOW;
    end else if (tgt_s > TARGET_HIGH) begin
      tgt_c = TARGET_HIGH;
    end else begin
      tgt_c = tgt_s;
    end

    // segment setup: span, clamped offset, end-value difference
    lo21   = {seg.lo[19], seg.lo};
    hi21   = {seg.hi[19], seg.hi};
    span21 = hi21 - lo21;
    e_s    = err_r;
    if (e_s < $signed(seg.lo)) begin
      e_c = seg.lo;
    end else if (e_s > $signed(seg.hi)) begin
      e_c = seg.hi;
    end else begin
      e_c = e_s;
    end
    off21 = {e_c[19], e_c} - lo21;
    dba17 = {seg.b[15], seg.b} - {seg.a[15], seg.a};
    mag17 = dba17[16] ? 17'(-dba17) : 17'(dba17);

    md_req.x   = off21[18:0];
    md_req.y   = mag17[15:0];
    md_req.den = span21[18:0];

    // saturate the opening
    res_s = res_r;
    if (res_s > OPEN_LIMIT) begin
      op = 16'(OPEN_LIMIT);
    end else if (res_s < -OPEN_LIMIT) begin
      op = 16'(-OPEN_LIMIT);
    end else begin
      op = res_s[15:0];
    end
    op_neg = -op;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_tuser[0];
          rise_nxt  = in_tuser[1];
          tgt_nxt   = in_tdata[18:0];
          meas_nxt  = in_tdata[37:19];
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        err_nxt   = 20'({tgt_c[18], tgt_c} - {meas_r[18], meas_r});
        state_nxt = ST_BAND;
      end
      ST_BAND: begin
        priority if (seg.hold) begin
          res_nxt   = {{2{last_r[15]}}, last_r};
          state_nxt = ST_DONE;
        end else if (span21 <= 21'sd0) begin
          // empty segment gives its start value
          res_nxt   = {{2{seg.a[15]}}, seg.a};
          state_nxt = ST_DONE;
        end else begin
          a_nxt     = seg.a;
          neg_nxt   = dba17[16];
          md_start  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (md_done) begin
          // quotient magnitude with the sign of b - a, so rounding is toward zero
          res_nxt = neg_r ? 18'({{2{a_r[15]}}, a_r} - {2'b0, md_quo})
                          : 18'({{2{a_r[15]}}, a_r} + {2'b0, md_quo});
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (cmd_r) begin
            mode_nxt = rise_r;
          end
          last_nxt      = op;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b0,
                           (op < 0) ? op_neg[14:0] : 15'd0,
                           (op > 0) ? op[14:0] : 15'd0,
                           op};
          out_user_nxt  = cmd_r ? rise_r : mode_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign cfg_ready  = 1'b1;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

  a_duty_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[30:16] != 15'd0 && out_tdata[45:31] != 15'd0))
    else $error("inflate and exhaust duty both active");

  a_opening_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] != 16'h8000)
    else $error("opening outside saturation range");

endmodule

// ===== bench/pvdc_tb_pkg.sv =====
// regulation mode codes shared by the valve controller bench files
`timescale 1ns / 1ps

package pvdc_tb_pkg;

  typedef enum logic {
    CMD_PLAIN      = 1'b0,
    CMD_RATE_AWARE = 1'b1
  } regulation_mode_t;

endpackage

// ===== bench/pvdc_checker.sv =====
// checker that predicts valve openings and compares them with the block's results
`timescale 1ns / 1ps

module pvdc_checker
  import pvdc_pkg::*;
  import pvdc_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    awaiting,
  output int                    results_checked,
  output int                    held_openings
);

  typedef struct {
    logic signed [15:0] opening;
    logic [14:0]        inflate;
    logic [14:0]        exhaust;
    logic               inflating;
  } valve_result_t;

  // register defaults after reset
  localparam longint DEAD_ZONE_RST    = 2000;
  localparam longint SPAN_RST         = 20000;
  localparam longint OPEN_MIN_POS_RST = 5898;
  localparam longint OPEN_MAX_POS_RST = 7537;
  localparam longint OPEN_MIN_NEG_RST = -9011;
  localparam longint OPEN_MAX_NEG_RST = -8520;

  longint dead_zone, inflate_span, deflate_span;
  longint min_pos, max_pos, min_neg, max_neg;
  longint prev_opening;
  logic   inflating_mode;

  valve_result_t expected_openings[$];
  valve_result_t want;
  regulation_mode_t mode;
  logic   rising;
  longint target, measured, err, op;

  // clamped linear segment, truncating division, empty segment gives its start value
  function automatic longint segment_opening(longint e, longint lo, longint hi,
                                             longint a, longint b);
    longint x;
    if (hi <= lo) return a;
    x = (e < lo) ? lo : ((e > hi) ? hi : e);
    return a + (x - lo) * (b - a) / (hi - lo);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dead_zone      = DEAD_ZONE_RST;
      inflate_span   = SPAN_RST;
      deflate_span   = SPAN_RST;
      min_pos        = OPEN_MIN_POS_RST;
      max_pos        = OPEN_MAX_POS_RST;
      min_neg        = OPEN_MIN_NEG_RST;
      max_neg        = OPEN_MAX_NEG_RST;
      prev_opening   = 0;
      inflating_mode = 1'b1;
      expected_openings.delete();
      mismatches      = 0;
      results_checked = 0;
      held_openings   = 0;
    end else begin
      // results first, so a result can never match a request accepted on the same edge
      if (out_tvalid && out_tready) begin
        if (expected_openings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, opening %0d", $time,
                   $signed(out_tdata[15:0]));
        end else begin
          want = expected_openings.pop_front();
          results_checked++;
          if (out_tdata[15:0] !== want.opening) begin
            mismatches++;
            $display("%0t: valve_opening expected %0d got %0d", $time,
                     want.opening, $signed(out_tdata[15:0]));
          end
          if (out_tdata[30:16] !== want.inflate) begin
            mismatches++;
            $display("%0t: inflate_duty expected %0d got %0d", $time,
                     want.inflate, out_tdata[30:16]);
          end
          if (out_tdata[45:31] !== want.exhaust) begin
            mismatches++;
            $display("%0t: exhaust_duty expected %0d got %0d", $time,
                     want.exhaust, out_tdata[45:31]);
          end
          if (out_tuser[0] !== want.inflating) begin
            mismatches++;
            $display("%0t: inflating expected %0b got %0b", $time,
                     want.inflating, out_tuser[0]);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEAD_ZONE:    dead_zone    = longint'(cfg_data[15:0]);
          CFG_INFLATE_SPAN: inflate_span = longint'(cfg_data[17:0]);
          CFG_DEFLATE_SPAN: deflate_span = longint'(cfg_data[17:0]);
          CFG_OPEN_MIN_POS: min_pos      = longint'(cfg_data[14:0]);
          CFG_OPEN_MAX_POS: max_pos      = longint'(cfg_data[14:0]);
          CFG_OPEN_MIN_NEG: min_neg      = longint'($signed(cfg_data[15:0]));
          CFG_OPEN_MAX_NEG: max_neg      = longint'($signed(cfg_data[15:0]));
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        mode     = regulation_mode_t'(in_tuser[0]);
        rising   = in_tuser[1];
        target   = longint'($signed(in_tdata[18:0]));
        measured = longint'($signed(in_tdata[37:19]));
        if (target < longint'(TARGET_LOW))  target = longint'(TARGET_LOW);
        if (target > longint'(TARGET_HIGH)) target = longint'(TARGET_HIGH);
        err = target - measured;

        if (mode == CMD_PLAIN) begin
          if (err > dead_zone)
            op = segment_opening(err, dead_zone, inflate_span, min_pos, max_pos);
          else if (err < -dead_zone)
            op = segment_opening(err, -deflate_span, -dead_zone, min_neg, max_neg);
          else
            op = 0;
        end else if (rising) begin
          inflating_mode = 1'b1;
          if (err > dead_zone)
            op = segment_opening(err, dead_zone, inflate_span, min_pos, max_pos);
          else if (err < -dead_zone * RISE_BAND_FACTOR)
            op = segment_opening(err, -deflate_span, -dead_zone, min_neg, max_neg);
          else
            op = segment_opening(err, -deflate_span, dead_zone, 0, min_pos);
        end else begin
          inflating_mode = 1'b0;
          if (err < -dead_zone)
            // falling target uses the inflate span on the exhaust side
            op = segment_opening(err, -inflate_span, -dead_zone, min_neg, max_neg);
          else if (err > dead_zone * HOLD_BAND_FACTOR) begin
            op = prev_opening;
            held_openings++;
          end else
            op = segment_opening(err, -dead_zone, 0, max_neg, 0);
        end

        if (op > longint'(OPEN_LIMIT))  op = longint'(OPEN_LIMIT);
        if (op < -longint'(OPEN_LIMIT)) op = -longint'(OPEN_LIMIT);
        prev_opening = op;

        want.opening   = op[15:0];
        want.inflate   = (op > 0) ? op[14:0] : 15'd0;
        want.exhaust   = (op < 0) ? 15'(-op) : 15'd0;
        want.inflating = inflating_mode;
        expected_openings.push_back(want);
      end
    end
    awaiting = expected_openings.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// stimulus and verdict for the pressure valve dead-zone controller
`timescale 1ns / 1ps

module tb_top;
  import pvdc_pkg::*;
  import pvdc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;  // several times the slowest legal run
  localparam int LONG_HOLD   = 300;     // receiver hold-off, long enough to back up the input
  localparam int DRAIN_WAIT  = 40;      // extra settle time after the last result

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // target_pressure[18:0], measured_pressure[37:19], pad
  logic [IN_USER_W-1:0]  in_tuser;   // command[0], target_rising[1]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // valve_opening, inflate_duty, exhaust_duty, pad
  logic [OUT_USER_W-1:0] out_tuser;  // inflating[0]
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches, awaiting, results_checked, held_openings;

  // shared between stimulus and the result sink
  bit     idle_on;
  int     hold_requests;
  // stimulus copy of the band registers, used to aim errors at band edges
  longint cur_dz, cur_ip, cur_dp;
  int     requests_sent;
  int     settings_loaded;

  always #4 clk = ~clk;

  pressure_valve_deadzone_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pvdc_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .results_checked (results_checked),
    .held_openings   (held_openings)
  );

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still awaited", CYCLE_LIMIT, awaiting);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result sink: random short stalls, plus a long hold-off when stimulus asks for one
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int holds_served;
    out_tready   = 1'b0;
    stall_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // one request; valid stays up afterwards so back-to-back requests need no extra edge
  task automatic send_req(regulation_mode_t mode, logic signed [18:0] target,
                          logic signed [18:0] measured, logic rising);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {2'b00, measured, target};
    in_tuser  = {rising, mode};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted opening has come back
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    case (idx)
      CFG_DEAD_ZONE:    cur_dz = longint'(val[15:0]);
      CFG_INFLATE_SPAN: cur_ip = longint'(val);
      CFG_DEFLATE_SPAN: cur_dp = longint'(val);
      default: ;
    endcase
  endtask

  // all seven registers, only with the block drained
  task automatic load_settings(logic [17:0] dz, logic [17:0] ip, logic [17:0] dp,
                               logic [17:0] minp, logic [17:0] maxp,
                               logic [17:0] minn, logic [17:0] maxn);
    wait_drained();
    write_reg(CFG_DEAD_ZONE, dz);
    write_reg(CFG_INFLATE_SPAN, ip);
    write_reg(CFG_DEFLATE_SPAN, dp);
    write_reg(CFG_OPEN_MIN_POS, minp);
    write_reg(CFG_OPEN_MAX_POS, maxp);
    write_reg(CFG_OPEN_MIN_NEG, minn);
    write_reg(CFG_OPEN_MAX_NEG, maxn);
    cfg_valid = 1'b0;
    settings_loaded++;
  endtask

  // random request, with the error mostly aimed at band edges of the current settings
  task automatic random_req();
    longint t, m, e;
    int kind;
    regulation_mode_t mode;
    logic rising;
    mode   = regulation_mode_t'($urandom_range(0, 1));
    rising = 1'($urandom_range(0, 1));
    t      = longint'($urandom_range(0, 280000)) - 100000;
    kind   = $urandom_range(0, 7);
    case (kind)
      0: e = cur_dz + longint'($urandom_range(0, 6)) - 3;
      1: e = -cur_dz + longint'($urandom_range(0, 6)) - 3;
      2: e = longint'($urandom_range(0, int'(cur_ip + cur_dz)));
      3: e = -longint'($urandom_range(0, int'(cur_dp + cur_dz)));
      4: e = -cur_dz * RISE_BAND_FACTOR + longint'($urandom_range(0, 6)) - 3;
      5: e = cur_dz * HOLD_BAND_FACTOR + longint'($urandom_range(0, 20000)) - 3;
      6: e = longint'($urandom_range(0, int'(2 * cur_dz))) - cur_dz;
      default: e = 0;
    endcase
    if (kind == 7) begin
      // unconstrained: covers every bit and targets beyond the clamp
      t = longint'($signed(19'($urandom)));
      m = longint'($signed(19'($urandom)));
    end else begin
      m = t - e;
      if (m < -262144 || m > 262143) m = longint'($signed(19'($urandom)));
    end
    send_req(mode, 19'(t), 19'(m), rising);
  endtask

  // random register values inside their ranges, or raw bits now and then
  task automatic random_settings(bit raw);
    if (raw)
      load_settings(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
                    18'($urandom), 18'($urandom), 18'($urandom));
    else
      load_settings(18'($urandom_range(0, 6000)), 18'($urandom_range(1, 60000)),
                    18'($urandom_range(1, 60000)), 18'($urandom_range(0, 32767)),
                    18'($urandom_range(0, 32767)), 18'(-int'($urandom_range(0, 32767))),
                    18'(-int'($urandom_range(0, 32767))));
  endtask

  initial begin : stimulus
    int i;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_DEAD_ZONE;
    cfg_data        = '0;
    idle_on         = 1'b0;
    hold_requests   = 0;
    requests_sent   = 0;
    settings_loaded = 0;
    cur_dz          = 2000;
    cur_ip          = 20000;
    cur_dp          = 20000;
    rst_n           = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n   = 1'b1;
    idle_on = 1'b1;

    // directed requests on the reset settings: dead zone 2000, spans 20000
    send_req(CMD_PLAIN, 0, 0, 1'b0);                   // zero error
    send_req(CMD_PLAIN, 2000, 0, 1'b0);                // exactly on the dead zone
    send_req(CMD_PLAIN, 2001, 0, 1'b0);                // just past it
    send_req(CMD_PLAIN, 20000, 0, 1'b0);               // at the inflate span
    send_req(CMD_PLAIN, 262143, -262144, 1'b1);        // both field extremes, clamped target
    send_req(CMD_PLAIN, 0, 2000, 1'b0);                // negative dead zone edge
    send_req(CMD_PLAIN, 0, 2001, 1'b0);
    send_req(CMD_PLAIN, 0, 20000, 1'b0);               // at the deflate span
    send_req(CMD_PLAIN, -262144, 262143, 1'b1);        // lowest target, highest measured
    send_req(CMD_RATE_AWARE, 5000, 0, 1'b1);           // rising, inflate band
    send_req(CMD_RATE_AWARE, 0, 20001, 1'b1);          // rising, below ten dead zones
    send_req(CMD_RATE_AWARE, 0, 20000, 1'b1);          // rising, on the ten dead zone edge
    send_req(CMD_RATE_AWARE, 0, 5000, 1'b1);           // rising, wide middle band
    send_req(CMD_RATE_AWARE, 0, 0, 1'b1);
    send_req(CMD_RATE_AWARE, 0, 3000, 1'b0);           // falling, exhaust band
    send_req(CMD_RATE_AWARE, 0, -1000, 1'b0);          // falling, middle above zero
    send_req(CMD_RATE_AWARE, 0, 1000, 1'b0);           // falling, middle below zero
    send_req(CMD_RATE_AWARE, 0, -200001, 1'b0);        // falling, hold band keeps opening
    send_req(CMD_RATE_AWARE, 0, -200000, 1'b0);        // on the hold edge
    send_req(CMD_RATE_AWARE, 180000, -262144, 1'b0);   // hold again, largest error
    send_req(CMD_PLAIN, 1000, 0, 1'b1);                // plain keeps inflating cleared
    send_req(CMD_PLAIN, -100000, -100000, 1'b0);       // target on the low clamp
    send_req(CMD_PLAIN, 180001, 0, 1'b0);              // one past the high clamp

    // reset settings, random; long receiver hold-off partway through
    for (i = 0; i < 120; i++) begin
      if (i == 30) hold_requests++;
      random_req();
    end

    // huge dead zone, one-pascal spans: inflate and exhaust segments empty;
    // strongest exhaust written below the opening range to force saturation
    load_settings(18'd65535, 18'd1, 18'd1, 18'd0, 18'd32767, 18'(-32768), 18'd0);
    for (i = 0; i < 80; i++) random_req();

    // no dead zone, widest spans, reversed slopes; hold band starts at zero error
    load_settings(18'd0, 18'd262143, 18'd262143, 18'd32767, 18'd0, 18'd0, 18'(-32767));
    for (i = 0; i < 80; i++) begin
      if (i == 40) wait_drained();  // sender pauses until the block is empty
      random_req();
    end

    // one-pascal dead zone and spans: inflate and exhaust segments collapse to a single point
    load_settings(18'd1, 18'd1, 18'd1, 18'd32767, 18'd32767, 18'(-32767), 18'(-32767));
    for (i = 0; i < 60; i++) random_req();

    for (int s = 0; s < 4; s++) begin
      random_settings(s == 2);
      for (i = 0; i < 60; i++) random_req();
    end

    // closing stretch, no idling on either side, hold band within reach
    load_settings(18'd500, 18'd30000, 18'd25000, 18'd4000, 18'd9000, 18'(-12000),
                  18'(-3000));
    idle_on = 1'b0;
    for (i = 0; i < 120; i++) random_req();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d requests over %0d register settings, %0d results checked",
             requests_sent, settings_loaded + 1, results_checked);
    $display("%0d openings held in the falling hold band, %0d mismatches",
             held_openings, mismatches);
    if (mismatches == 0 && awaiting == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
